@@ rtl/pcs_pkg.sv @@
// pcs_pkg: types and constants for the pneumatic clamp sequencer
// used by pcs_cfg_regs, pcs_core and pneumatic_clamp_sequencer; no dependencies
package pcs_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CNT_W      = 17;
    localparam int unsigned RUN_W      = 16;
    localparam int unsigned LIMIT_W    = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ADAPTER_SET_ID = 3'd0,
        CFG_STEP_DELAY     = 3'd1,
        CFG_SAMPLE_PERIOD  = 3'd2,
        CFG_SET_PRESSURE   = 3'd3,
        CFG_MAX_REL_ERROR  = 3'd4,
        CFG_MAX_ERROR_RUN  = 3'd5
    } cfg_idx_t;

    localparam logic [3:0]  RST_ADAPTER_SET_ID = 4'd0;
    localparam logic [15:0] RST_STEP_DELAY     = 16'd100;
    localparam logic [15:0] RST_SAMPLE_PERIOD  = 16'd10;
    localparam logic [15:0] RST_SET_PRESSURE   = 16'd1000;
    localparam logic [15:0] RST_MAX_REL_ERROR  = 16'd6554;
    localparam logic [15:0] RST_MAX_ERROR_RUN  = 16'd5;
    localparam logic [LIMIT_W-1:0] RST_ERR_LIMIT = 32'd6554000;

    typedef enum logic [2:0] {
        DEV_NONE      = 3'd0,
        DEV_READY     = 3'd1,
        DEV_CLAMPING  = 3'd2,
        DEV_CLAMPED   = 3'd3,
        DEV_RELEASING = 3'd4,
        DEV_FAULT     = 3'd5,
        DEV_HALT      = 3'd6
    } dev_state_t;

    typedef enum logic [2:0] {
        STEP_NONE         = 3'd0,
        STEP_BLOCK        = 3'd1,
        STEP_BLOCK_WAIT   = 3'd2,
        STEP_CLAMP_WAIT   = 3'd3,
        STEP_START_REL    = 3'd4,
        STEP_REL_WAIT     = 3'd5,
        STEP_UNBLOCK_WAIT = 3'd6
    } step_t;

    typedef enum logic [2:0] {
        CMD_HOMING      = 3'd0,
        CMD_CLR_FAULT   = 3'd1,
        CMD_CLR_WARNING = 3'd2,
        CMD_CLR_HALT    = 3'd3,
        CMD_CLAMP       = 3'd4,
        CMD_RELEASE     = 3'd5,
        CMD_HALT        = 3'd6,
        CMD_CHECK_ADPT  = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        UERR_NONE      = 2'd0,
        UERR_BLOCKED   = 2'd1,
        UERR_NOT_READY = 2'd2
    } user_err_t;

    typedef enum logic [2:0] {
        PROB_NONE         = 3'd0,
        PROB_TOP_OPEN     = 3'd1,
        PROB_BOT_OPEN     = 3'd2,
        PROB_TOP_MISMATCH = 3'd3,
        PROB_BOT_MISMATCH = 3'd4
    } problem_t;

    typedef enum logic [1:0] {
        RES_NONE = 2'd0,
        RES_OK   = 2'd1,
        RES_FAIL = 2'd2
    } op_result_t;

    localparam logic REQ_TICK = 1'b0;

    localparam logic [5:0] DRV_TOP        = 6'h01;
    localparam logic [5:0] DRV_BOT        = 6'h02;
    localparam logic [5:0] DRV_DEV        = 6'h04;
    localparam logic [5:0] DRV_ADPT_LAMP  = 6'h08;
    localparam logic [5:0] DRV_CLAMP_LAMP = 6'h10;
    localparam logic [5:0] DRV_SAFETY     = 6'h20;

    typedef struct packed {
        logic        req_type;
        cmd_t        command;
        logic        top_switch_open;
        logic        bottom_switch_open;
        logic [3:0]  top_adapter_id;
        logic [3:0]  bottom_adapter_id;
        logic [15:0] pressure_sample;
    } in_word_t;

    typedef struct packed {
        dev_state_t  device_state;
        step_t       step_state;
        user_err_t   user_error;
        problem_t    problem_code;
        op_result_t  op_result;
        logic        fault_reason;
        logic [5:0]  drive_bits;
        logic        top_mismatch;
        logic        bottom_mismatch;
    } out_word_t;

    typedef struct packed {
        logic [3:0]         adapter_set_id;
        logic [15:0]        step_delay;
        logic [15:0]        sample_period;
        logic [15:0]        set_pressure;
        logic [15:0]        max_error_run;
        logic [LIMIT_W-1:0] err_limit;
    } cfg_t;

endpackage

@@ rtl/pcs_cfg_regs.sv @@
// pcs_cfg_regs: configuration registers and the registered pressure error limit
// depends on pcs_pkg
module pcs_cfg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [pcs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pcs_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    output pcs_pkg::cfg_t                        cfg
);
    import pcs_pkg::*;

    logic [3:0]         adapter_set_id_reg;
    logic [15:0]        step_delay_reg;
    logic [15:0]        sample_period_reg;
    logic [15:0]        set_pressure_reg;
    logic [15:0]        max_rel_error_reg;
    logic [15:0]        max_error_run_reg;
    logic [LIMIT_W-1:0] err_limit_reg;
    logic [LIMIT_W-1:0] err_limit_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adapter_set_id_reg <= RST_ADAPTER_SET_ID;
            step_delay_reg     <= RST_STEP_DELAY;
            sample_period_reg  <= RST_SAMPLE_PERIOD;
            set_pressure_reg   <= RST_SET_PRESSURE;
            max_rel_error_reg  <= RST_MAX_REL_ERROR;
            max_error_run_reg  <= RST_MAX_ERROR_RUN;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ADAPTER_SET_ID: adapter_set_id_reg <= cfg_wdata[3:0];
                CFG_STEP_DELAY:     step_delay_reg     <= cfg_wdata;
                CFG_SAMPLE_PERIOD:  sample_period_reg  <= cfg_wdata;
                CFG_SET_PRESSURE:   set_pressure_reg   <= cfg_wdata;
                CFG_MAX_REL_ERROR:  max_rel_error_reg  <= cfg_wdata;
                CFG_MAX_ERROR_RUN:  max_error_run_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // allowed error scaled by the set point, rebuilt every cycle
    assign err_limit_next = LIMIT_W'(max_rel_error_reg) * LIMIT_W'(set_pressure_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_limit_reg <= RST_ERR_LIMIT;
        end
        else
        begin
            err_limit_reg <= err_limit_next;
        end
    end

    assign cfg.adapter_set_id = adapter_set_id_reg;
    assign cfg.step_delay     = step_delay_reg;
    assign cfg.sample_period  = sample_period_reg;
    assign cfg.set_pressure   = set_pressure_reg;
    assign cfg.max_error_run  = max_error_run_reg;
    assign cfg.err_limit      = err_limit_reg;

endmodule

@@ rtl/pcs_core.sv @@
// pcs_core: input register, sequencer state update and result register
// depends on pcs_pkg; configuration comes from pcs_cfg_regs
module pcs_core (
    input  logic               clk,
    input  logic               rst_n,
    input  pcs_pkg::cfg_t      cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  pcs_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output pcs_pkg::out_word_t out_data
);
    import pcs_pkg::*;

    logic                 in_full_reg;
    in_word_t             in_word_reg;
    logic                 out_valid_reg;
    out_word_t            out_word_reg;
    logic                 step_fire;

    dev_state_t           state_reg, state_next;
    step_t                step_reg, step_next;
    logic [CNT_W-1:0]     delay_cnt_reg, delay_cnt_next;
    logic [CNT_W-1:0]     sample_cnt_reg, sample_cnt_next;
    logic [RUN_W-1:0]     bad_run_reg, bad_run_next;
    logic [5:0]           drive_reg, drive_next;
    problem_t             problem_reg, problem_next;
    op_result_t           result_reg, result_next;
    logic                 fault_reg, fault_next;
    logic [1:0]           mismatch_reg, mismatch_next;
    user_err_t            uerr;

    logic [15:0]          diff;
    logic [LIMIT_W-1:0]   scaled_diff;
    logic                 done;
    logic                 top_bad, bot_bad;

    assign step_fire = in_full_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_full_reg || step_fire;
    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    assign top_bad = in_word_reg.top_adapter_id != cfg.adapter_set_id;
    assign bot_bad = in_word_reg.bottom_adapter_id != cfg.adapter_set_id;
    assign diff = (in_word_reg.pressure_sample >= cfg.set_pressure)
                ? in_word_reg.pressure_sample - cfg.set_pressure
                : cfg.set_pressure - in_word_reg.pressure_sample;
    assign scaled_diff = {diff, 16'h0000};

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        delay_cnt_next  = delay_cnt_reg;
        sample_cnt_next = sample_cnt_reg;
        bad_run_next    = bad_run_reg;
        drive_next      = drive_reg;
        problem_next    = problem_reg;
        result_next     = result_reg;
        fault_next      = fault_reg;
        mismatch_next   = mismatch_reg;
        uerr            = UERR_NONE;

        if (in_word_reg.req_type == REQ_TICK)
        begin
            if (delay_cnt_reg != '1)
            begin
                delay_cnt_next = delay_cnt_reg + CNT_W'(1);
            end
            if (sample_cnt_reg != '1)
            begin
                sample_cnt_next = sample_cnt_reg + CNT_W'(1);
            end
            if (sample_cnt_next > {1'b0, cfg.sample_period})
            begin
                sample_cnt_next = '0;
                if (state_reg == DEV_READY || state_reg == DEV_CLAMPING ||
                    state_reg == DEV_CLAMPED || state_reg == DEV_RELEASING)
                begin
                    if (scaled_diff > cfg.err_limit)
                    begin
                        if (bad_run_reg != '1)
                        begin
                            bad_run_next = bad_run_reg + RUN_W'(1);
                        end
                    end
                    else
                    begin
                        bad_run_next = '0;
                    end
                    if (bad_run_next > cfg.max_error_run)
                    begin
                        drive_next  = '0;
                        state_next  = DEV_FAULT;
                        step_next   = STEP_NONE;
                        fault_next  = 1'b1;
                        result_next = RES_FAIL;
                    end
                end
            end
        end
        else
        begin
            unique case (in_word_reg.command)
                CMD_HOMING:
                begin
                    if (state_reg == DEV_NONE)
                    begin
                        state_next = DEV_READY;
                        step_next  = STEP_NONE;
                    end
                    else if (state_reg != DEV_READY)
                    begin
                        uerr = UERR_BLOCKED;
                    end
                end
                CMD_CLR_FAULT:
                begin
                    if (state_reg == DEV_FAULT)
                    begin
                        state_next = DEV_NONE;
                        step_next  = STEP_NONE;
                        fault_next = 1'b0;
                    end
                end
                CMD_CLR_WARNING: ;
                CMD_CLR_HALT:
                begin
                    if (state_reg == DEV_HALT)
                    begin
                        state_next = DEV_READY;
                        step_next  = STEP_NONE;
                    end
                end
                CMD_CLAMP:
                begin
                    if (state_reg == DEV_READY)
                    begin
                        priority if (in_word_reg.top_switch_open)
                            problem_next = PROB_TOP_OPEN;
                        else if (in_word_reg.bottom_switch_open)
                            problem_next = PROB_BOT_OPEN;
                        else if (top_bad)
                            problem_next = PROB_TOP_MISMATCH;
                        else if (bot_bad)
                            problem_next = PROB_BOT_MISMATCH;
                        else
                            problem_next = PROB_NONE;
                        if (problem_next == PROB_NONE)
                        begin
                            result_next = RES_NONE;
                            state_next  = DEV_CLAMPING;
                            step_next   = STEP_BLOCK;
                        end
                        else
                        begin
                            result_next = RES_FAIL;
                        end
                    end
                    else if (state_reg == DEV_CLAMPING)
                    begin
                        uerr = UERR_BLOCKED;
                    end
                    else
                    begin
                        uerr = UERR_NOT_READY;
                    end
                end
                CMD_RELEASE:
                begin
                    if (state_reg == DEV_CLAMPED)
                    begin
                        result_next = RES_NONE;
                        state_next  = DEV_RELEASING;
                        step_next   = STEP_START_REL;
                    end
                    else if (state_reg == DEV_RELEASING)
                    begin
                        uerr = UERR_BLOCKED;
                    end
                    else
                    begin
                        uerr = UERR_NOT_READY;
                    end
                end
                CMD_HALT:
                begin
                    state_next = DEV_HALT;
                    step_next  = STEP_NONE;
                end
                CMD_CHECK_ADPT:
                begin
                    mismatch_next = {bot_bad, top_bad};
                end
                default: ;
            endcase
        end

        // clamp and release sub-steps, at most one per word
        done = delay_cnt_next > {1'b0, cfg.step_delay};
        if (state_next == DEV_CLAMPING || state_next == DEV_RELEASING)
        begin
            unique case (step_next)
                STEP_BLOCK:
                begin
                    delay_cnt_next = '0;
                    drive_next     = drive_next | DRV_TOP | DRV_BOT;
                    state_next     = DEV_CLAMPING;
                    step_next      = STEP_BLOCK_WAIT;
                end
                STEP_BLOCK_WAIT:
                begin
                    if (done)
                    begin
                        delay_cnt_next = '0;
                        drive_next     = drive_next | DRV_ADPT_LAMP | DRV_DEV;
                        state_next     = DEV_CLAMPING;
                        step_next      = STEP_CLAMP_WAIT;
                    end
                end
                STEP_CLAMP_WAIT:
                begin
                    if (done)
                    begin
                        drive_next  = drive_next | DRV_CLAMP_LAMP | DRV_SAFETY;
                        result_next = RES_OK;
                        state_next  = DEV_CLAMPED;
                        step_next   = STEP_NONE;
                    end
                end
                STEP_START_REL:
                begin
                    delay_cnt_next = '0;
                    drive_next     = drive_next & ~(DRV_SAFETY | DRV_CLAMP_LAMP | DRV_DEV);
                    state_next     = DEV_RELEASING;
                    step_next      = STEP_REL_WAIT;
                end
                STEP_REL_WAIT:
                begin
                    if (done)
                    begin
                        delay_cnt_next = '0;
                        drive_next     = drive_next & ~(DRV_TOP | DRV_BOT);
                        state_next     = DEV_RELEASING;
                        step_next      = STEP_UNBLOCK_WAIT;
                    end
                end
                STEP_UNBLOCK_WAIT:
                begin
                    if (done)
                    begin
                        drive_next  = drive_next & ~DRV_ADPT_LAMP;
                        result_next = RES_OK;
                        state_next  = DEV_READY;
                        step_next   = STEP_NONE;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= DEV_NONE;
            step_reg       <= STEP_NONE;
            delay_cnt_reg  <= '0;
            sample_cnt_reg <= '1;
            bad_run_reg    <= '0;
            drive_reg      <= '0;
            problem_reg    <= PROB_NONE;
            result_reg     <= RES_NONE;
            fault_reg      <= 1'b0;
            mismatch_reg   <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                in_full_reg <= 1'b1;
            end
            else if (step_fire)
            begin
                in_full_reg <= 1'b0;
            end

            if (step_fire)
            begin
                out_valid_reg  <= 1'b1;
                state_reg      <= state_next;
                step_reg       <= step_next;
                delay_cnt_reg  <= delay_cnt_next;
                sample_cnt_reg <= sample_cnt_next;
                bad_run_reg    <= bad_run_next;
                drive_reg      <= drive_next;
                problem_reg    <= problem_next;
                result_reg     <= result_next;
                fault_reg      <= fault_next;
                mismatch_reg   <= mismatch_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_word_reg <= in_data;
        end
        if (step_fire)
        begin
            out_word_reg.device_state    <= state_next;
            out_word_reg.step_state      <= step_next;
            out_word_reg.user_error      <= uerr;
            out_word_reg.problem_code    <= problem_next;
            out_word_reg.op_result       <= result_next;
            out_word_reg.fault_reason    <= fault_next;
            out_word_reg.drive_bits      <= drive_next;
            out_word_reg.top_mismatch    <= mismatch_next[0];
            out_word_reg.bottom_mismatch <= mismatch_next[1];
        end
    end

    // outputs stay dropped while faulted
    a_fault_drive_off: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == DEV_FAULT) |-> (drive_reg == '0))
        else $error("drive active in fault state");

    a_fault_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == DEV_FAULT) |-> fault_reg)
        else $error("fault state without fault reason");

    a_step_in_sequence: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg != STEP_NONE) |->
            (state_reg == DEV_CLAMPING || state_reg == DEV_RELEASING))
        else $error("sub-step outside clamp or release");

    a_held_word: assert property (@(posedge clk) disable iff (!rst_n)
        (in_full_reg && !step_fire) |=> (in_full_reg && $stable(in_word_reg)))
        else $error("stalled input word lost");

endmodule

@@ rtl/pneumatic_clamp_sequencer.sv @@
// pneumatic_clamp_sequencer: top level of the clamp sequencer
// depends on pcs_pkg, pcs_cfg_regs and pcs_core
//
//   port group                  dir   meaning
//   in_valid/in_ready/in_data   in    tick or operator command word
//   out_valid/out_ready/out_data out  one status word per input word
//   cfg_we/cfg_index/cfg_wdata  in    register write, no wait
//
// one word per cycle sustained while out_ready is high; an accepted word goes into
// the input register, then the state update writes its result into the result register
// the state registers and the result register load together, so each word sees
// the state left by the one before
// reset clears state to none, counters to zero and the sample counter to all ones
// a result held by out_ready low stalls the input register; one more word is taken
module pneumatic_clamp_sequencer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  pcs_pkg::in_word_t              in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output pcs_pkg::out_word_t             out_data,
    input  logic                           cfg_we,
    input  logic [pcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pcs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import pcs_pkg::*;

    cfg_t cfg;

    pcs_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pcs_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
